[hw/rtl/sawe_pkg.sv]
// ----------------------------------------------------------------------------
// Size and age weighted evictor package
// Types, sizes and codes shared by the evictor, its divider and its checker.
// ----------------------------------------------------------------------------
package sawe_pkg;

   localparam int SLOTS_DEFAULT    = 64;
   localparam int AGE_BITS_DEFAULT = 16;
   localparam int SIZE_BITS        = 29;
   localparam int DIM_BITS         = 14;
   localparam int MAX_DIM          = 8192;
   localparam int MAX_CHANNELS     = 4;
   localparam int SLOT_FIELD_BITS  = 6;
   localparam int DIV_CNT_BITS     = $clog2(SIZE_BITS + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PURGE  = 2'd2,
      OP_NONE   = 2'd3
   } sawe_op_type;

   typedef enum logic [2:0] {
      STATUS_OK             = 3'd0,
      STATUS_BAD_CHANNELS   = 3'd1,
      STATUS_BAD_SIZE       = 3'd2,
      STATUS_OCCUPIED       = 3'd3,
      STATUS_ABSENT         = 3'd4,
      STATUS_NONE_EVICTABLE = 3'd5
   } sawe_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_MUL,
      ST_INS_CHK,
      ST_INS_WR,
      ST_REM_RD,
      ST_REM_CHK,
      ST_AGE_RD,
      ST_AGE_WR,
      ST_SC_RD,
      ST_SC_CHK,
      ST_SC_START,
      ST_SC_WAIT,
      ST_EVICT,
      ST_RESP
   } sawe_state_type;

   typedef struct packed {
      sawe_op_type                operation;
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic [DIM_BITS-1:0]        width;
      logic [DIM_BITS-1:0]        height;
      logic [2:0]                 channels;
      logic                       from_preset;
   } sawe_req_type;

   typedef struct packed {
      sawe_status_type            status;
      logic [SLOT_FIELD_BITS-1:0] evicted_slot;
      logic                       notify_unload;
   } sawe_rsp_type;

endpackage

[hw/rtl/size_age_weighted_evictor_top.sv]
// ----------------------------------------------------------------------------
// Size and age weighted evictor
// Table of resident buffers with insert, remove and purge. A purge ages every
// entry and evicts the eligible entry with the largest age-weighted size.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake             Payload
//   req       in          req_valid/req_stall   req_data  (sawe_req_type)
//   rsp       out         rsp_valid/rsp_stall   rsp_data  (sawe_rsp_type)
//
// An insert that passes its checks runs ST_INS_MUL, ST_INS_CHK and ST_INS_WR
// (no ST_INS_WR if the slot is occupied), a remove ST_REM_RD and ST_REM_CHK;
// a rejected request or an unused operation goes straight to ST_RESP.
// A purge runs an ageing pass over all SLOTS entries, then a scoring pass that
// reads each entry and runs the bit-serial divider for each eligible entry
// when the ages differ, then evicts and responds.
// After reset a clearing pass over every slot runs before the first request.
// A new request is taken while an earlier result still waits on rsp_stall.
// ----------------------------------------------------------------------------
module size_age_weighted_evictor_top #(
   parameter int SLOTS    = sawe_pkg::SLOTS_DEFAULT,
   parameter int AGE_BITS = sawe_pkg::AGE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sawe_pkg::sawe_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sawe_pkg::sawe_rsp_type rsp_data
);
   import sawe_pkg::*;

   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int MUL_B_BITS    = (AGE_BITS > DIM_BITS) ? AGE_BITS : DIM_BITS;
   localparam int PROD_BITS     = SIZE_BITS + MUL_B_BITS;
   localparam int DIVIDEND_BITS = SIZE_BITS + AGE_BITS;
   localparam int ENTRY_BITS    = SIZE_BITS + AGE_BITS + 2;
   localparam logic [SLOT_BITS-1:0] LAST_IDX = SLOT_BITS'(SLOTS - 1);

   sawe_state_type         state_ff, state_in;
   sawe_req_type           req_ff, req_in;
   sawe_rsp_type           res_ff, res_in;
   sawe_rsp_type           rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [SLOT_BITS-1:0]   best_ff, best_in;
   logic                   best_preset_ff, best_preset_in;
   logic                   have_best_ff, have_best_in;
   logic [SIZE_BITS:0]     best_score_ff, best_score_in;
   logic [AGE_BITS-1:0]    least_ff, least_in;
   logic [AGE_BITS-1:0]    greatest_ff, greatest_in;
   logic                   any_ff, any_in;
   logic [SIZE_BITS-1:0]   cur_size_ff, cur_size_in;
   logic                   cur_preset_ff, cur_preset_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;

   logic [ENTRY_BITS-1:0]  entry_mem [SLOTS];
   logic [ENTRY_BITS-1:0]  rd_ff;
   logic [SLOT_BITS-1:0]   mem_addr;
   logic                   mem_we;
   logic [ENTRY_BITS-1:0]  mem_wdata;

   logic                   rd_valid;
   logic                   rd_preset;
   logic [SIZE_BITS-1:0]   rd_size;
   logic [AGE_BITS-1:0]    rd_age;
   logic [AGE_BITS-1:0]    age_next;
   logic                   rd_eligible;

   logic [SIZE_BITS-1:0]   mul_a;
   logic [MUL_B_BITS-1:0]  mul_b;
   logic                   div_start;
   logic                   div_done;
   logic [SIZE_BITS-1:0]   quotient;
   logic [AGE_BITS-1:0]    span;
   logic                   span_zero;

   logic                   accept;
   logic                   idx_last;
   logic                   ch_bad;
   logic                   dim_bad;
   logic                   slot_out;
   logic [SLOT_BITS-1:0]   req_addr;
   logic                   rsp_load;
   logic                   cand_valid;
   logic [SIZE_BITS:0]     cand_score;
   logic                   cand_preset;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_last  = (idx_ff == LAST_IDX);
   assign req_addr  = SLOT_BITS'(req_ff.slot);

   assign ch_bad   = (req_data.channels == 3'd0) || (req_data.channels > 3'(MAX_CHANNELS));
   assign dim_bad  = (req_data.width == '0) || (req_data.height == '0)
                     || (req_data.width > DIM_BITS'(MAX_DIM))
                     || (req_data.height > DIM_BITS'(MAX_DIM));
   assign slot_out = (32'(req_data.slot) >= 32'(SLOTS));

   assign rd_valid    = rd_ff[ENTRY_BITS-1];
   assign rd_preset   = rd_ff[ENTRY_BITS-2];
   assign rd_size     = rd_ff[AGE_BITS +: SIZE_BITS];
   assign rd_age      = rd_ff[AGE_BITS-1:0];
   assign age_next    = (rd_age == {AGE_BITS{1'b1}}) ? rd_age : rd_age + 1'b1;
   assign rd_eligible = rd_valid && (rd_age > AGE_BITS'(1));

   assign span      = greatest_ff - least_ff;
   assign span_zero = (span == '0);

   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   sawe_div #(
      .AGE_BITS(AGE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[DIVIDEND_BITS-1:0]),
      .divisor  (span),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.operation)
                  OP_INSERT: state_in = (ch_bad || dim_bad || slot_out) ? ST_RESP : ST_INS_MUL;
                  OP_REMOVE: state_in = slot_out ? ST_RESP : ST_REM_RD;
                  OP_PURGE:  state_in = ST_AGE_RD;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_INS_MUL:  state_in = ST_INS_CHK;
         ST_INS_CHK:  state_in = rd_valid ? ST_RESP : ST_INS_WR;
         ST_INS_WR:   state_in = ST_RESP;
         ST_REM_RD:   state_in = ST_REM_CHK;
         ST_REM_CHK:  state_in = ST_RESP;
         ST_AGE_RD:   state_in = ST_AGE_WR;
         ST_AGE_WR: begin
            if (idx_last) state_in = any_in ? ST_SC_RD : ST_RESP;
            else state_in = ST_AGE_RD;
         end
         ST_SC_RD:    state_in = ST_SC_CHK;
         ST_SC_CHK: begin
            if (rd_eligible && !span_zero) state_in = ST_SC_START;
            else state_in = idx_last ? ST_EVICT : ST_SC_RD;
         end
         ST_SC_START: state_in = ST_SC_WAIT;
         ST_SC_WAIT: begin
            if (div_done) state_in = idx_last ? ST_EVICT : ST_SC_RD;
         end
         ST_EVICT:    state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in         = req_ff;
      res_in         = res_ff;
      idx_in         = idx_ff;
      best_in        = best_ff;
      best_preset_in = best_preset_ff;
      have_best_in   = have_best_ff;
      best_score_in  = best_score_ff;
      least_in       = least_ff;
      greatest_in    = greatest_ff;
      any_in         = any_ff;
      cur_size_in    = cur_size_ff;
      cur_preset_in  = cur_preset_ff;
      mem_addr       = idx_ff;
      mem_we         = 1'b0;
      mem_wdata      = '0;
      mul_a          = '0;
      mul_b          = '0;
      div_start      = 1'b0;
      cand_valid     = 1'b0;
      cand_score     = '0;
      cand_preset    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_last ? '0 : idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               res_in = '{status: STATUS_OK, evicted_slot: '0, notify_unload: 1'b0};
               unique case (req_data.operation)
                  OP_INSERT: begin
                     if (ch_bad) res_in.status = STATUS_BAD_CHANNELS;
                     else if (dim_bad) res_in.status = STATUS_BAD_SIZE;
                     else if (slot_out) res_in.status = STATUS_ABSENT;
                  end
                  OP_REMOVE: begin
                     if (slot_out) res_in.status = STATUS_ABSENT;
                  end
                  OP_PURGE: begin
                     idx_in       = '0;
                     any_in       = 1'b0;
                     have_best_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_MUL: begin
            mem_addr = req_addr;
            mul_a    = SIZE_BITS'(req_ff.width);
            mul_b    = MUL_B_BITS'(req_ff.height);
         end
         ST_INS_CHK: begin
            mem_addr = req_addr;
            mul_a    = prod_ff[SIZE_BITS-1:0];
            mul_b    = MUL_B_BITS'(req_ff.channels);
            if (rd_valid) res_in.status = STATUS_OCCUPIED;
         end
         ST_INS_WR: begin
            mem_addr  = req_addr;
            mem_we    = 1'b1;
            mem_wdata = {1'b1, req_ff.from_preset, prod_ff[SIZE_BITS-1:0], {AGE_BITS{1'b0}}};
         end
         ST_REM_RD: begin
            mem_addr = req_addr;
         end
         ST_REM_CHK: begin
            mem_addr = req_addr;
            if (!rd_valid) begin
               res_in.status = STATUS_ABSENT;
            end else begin
               mem_we               = 1'b1;
               res_in.notify_unload = !rd_preset;
            end
         end
         ST_AGE_RD: ;
         ST_AGE_WR: begin
            if (rd_valid) begin
               mem_we    = 1'b1;
               mem_wdata = {rd_ff[ENTRY_BITS-1:AGE_BITS], age_next};
               if (age_next > AGE_BITS'(1)) begin
                  if (!any_ff || (age_next < least_ff)) least_in = age_next;
                  if (!any_ff || (age_next > greatest_ff)) greatest_in = age_next;
                  any_in = 1'b1;
               end
            end
            idx_in = idx_last ? '0 : idx_ff + 1'b1;
            if (idx_last && !any_in) res_in.status = STATUS_NONE_EVICTABLE;
         end
         ST_SC_RD: ;
         ST_SC_CHK: begin
            if (rd_eligible && !span_zero) begin
               mul_a         = rd_size;
               mul_b         = MUL_B_BITS'(rd_age - least_ff);
               cur_size_in   = rd_size;
               cur_preset_in = rd_preset;
            end else begin
               cand_valid  = rd_eligible;
               cand_score  = {1'b0, rd_size};
               cand_preset = rd_preset;
               idx_in      = idx_last ? '0 : idx_ff + 1'b1;
            end
         end
         ST_SC_START: begin
            div_start = 1'b1;
         end
         ST_SC_WAIT: begin
            if (div_done) begin
               cand_valid  = 1'b1;
               cand_score  = {1'b0, cur_size_ff} + {1'b0, quotient};
               cand_preset = cur_preset_ff;
               idx_in      = idx_last ? '0 : idx_ff + 1'b1;
            end
         end
         ST_EVICT: begin
            mem_addr = best_ff;
            mem_we   = 1'b1;
            res_in   = '{status: STATUS_OK, evicted_slot: SLOT_FIELD_BITS'(best_ff),
                         notify_unload: !best_preset_ff};
         end
         ST_RESP: ;
         default: ;
      endcase

      if (cand_valid && (!have_best_ff || (cand_score > best_score_ff))) begin
         have_best_in   = 1'b1;
         best_in        = idx_ff;
         best_score_in  = cand_score;
         best_preset_in = cand_preset;
      end
   end

   assign prod_in      = {{MUL_B_BITS{1'b0}}, mul_a} * {{SIZE_BITS{1'b0}}, mul_b};
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_in       = rsp_load ? res_ff : rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= entry_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         have_best_ff <= 1'b0;
         any_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         have_best_ff <= have_best_in;
         any_ff       <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      res_ff         <= res_in;
      rsp_ff         <= rsp_in;
      best_ff        <= best_in;
      best_preset_ff <= best_preset_in;
      best_score_ff  <= best_score_in;
      least_ff       <= least_in;
      greatest_ff    <= greatest_in;
      cur_size_ff    <= cur_size_in;
      cur_preset_ff  <= cur_preset_in;
      prod_ff        <= prod_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/sawe_div.sv]
// ----------------------------------------------------------------------------
// Evictor score divider
// Restoring divider that produces one quotient bit per cycle. The quotient is
// known to fit in SIZE_BITS, so the upper part of the dividend seeds the
// remainder directly.
// ----------------------------------------------------------------------------
module sawe_div #(
   parameter int AGE_BITS = sawe_pkg::AGE_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [sawe_pkg::SIZE_BITS+AGE_BITS-1:0] dividend,
   input  logic [AGE_BITS-1:0]                     divisor,
   output logic                                    done,
   output logic [sawe_pkg::SIZE_BITS-1:0]          quotient
);
   import sawe_pkg::*;

   logic [AGE_BITS-1:0]     rem_ff, rem_in;
   logic [SIZE_BITS-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [AGE_BITS:0]       trial;
   logic [AGE_BITS:0]       diff;
   logic                    fits;

   assign trial = {rem_ff, quo_ff[SIZE_BITS-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[SIZE_BITS +: AGE_BITS];
         quo_in  = dividend[SIZE_BITS-1:0];
         cnt_in  = DIV_CNT_BITS'(SIZE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[AGE_BITS-1:0] : trial[AGE_BITS-1:0];
         quo_in = {quo_ff[SIZE_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/sawe_checker.sv]
// ----------------------------------------------------------------------------
// Size and age weighted evictor checker
// Port-level assertions on the evictor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sawe_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input sawe_pkg::sawe_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sawe_pkg::sawe_rsp_type rsp_data
);
   import sawe_pkg::*;

   // The block starts its clearing pass straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (req_stall && !rsp_valid))
      else $error("block not busy and quiet after reset");

   // One request at a time: the block is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while the previous one was still in progress");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_data)))
      else $error("stalled request changed or was withdrawn");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or was dropped");

   // A freed slot or an unload notice only ever comes with a successful result.
   a_free_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.notify_unload || (rsp_data.evicted_slot != '0)))
         |-> (rsp_data.status == STATUS_OK))
      else $error("eviction or unload notice reported with a failure status");

endmodule

bind size_age_weighted_evictor_top sawe_checker u_checker (.*);
